FILE: rtl/core/ers_pkg.sv
package ers_pkg;

  localparam int POS_FRAC = 16;
  localparam int CFG_IDX_W = 3;
  localparam int ANGLE_W = 10;
  localparam int DEG_W = 9;
  localparam int QIDX_W = 7;
  localparam int TAB_DEPTH = 91;
  localparam longint SCALE_RESET = 65536;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Register stages from the angle registers to the slowest rotation matrix entries.
  localparam int MAT_LAT = 5;
  localparam int SETTLE_W = $clog2(MAT_LAT + 1);

  localparam int NUM_STAGES = 7;
  localparam int ST_PROD = 1;
  localparam int ST_SUM = 2;
  localparam int ST_RND = 3;
  localparam int ST_PRE = 4;
  localparam int ST_MUL = 5;
  localparam int ST_SCL = 6;
  localparam int ST_ADD = 7;
  localparam int NORM_DLY = ST_ADD - ST_RND;
  localparam int CNT_W = $clog2(NUM_STAGES + 2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORDER_MODE,
    REG_ANGLE_X,
    REG_ANGLE_Y,
    REG_ANGLE_Z,
    REG_SHIFT_X,
    REG_SHIFT_Y,
    REG_SHIFT_Z,
    REG_SCALE
  } cfg_reg_t;

  typedef struct packed {
    logic prod;
    logic sum;
    logic rnd;
  } lane_en_t;

  typedef struct packed {
    logic pre;
    logic mul;
    logic scl;
    logic add;
  } post_en_t;

endpackage

FILE: rtl/core/ers_coef.sv
module ers_coef #(
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                                   clk,
  input  logic signed [ers_pkg::ANGLE_W-1:0]     angle_x,
  input  logic signed [ers_pkg::ANGLE_W-1:0]     angle_y,
  input  logic signed [ers_pkg::ANGLE_W-1:0]     angle_z,
  output logic signed [COEF_FRAC_BITS+2:0]       mat [3][3]
);
  import ers_pkg::*;

  localparam int F = COEF_FRAC_BITS;
  localparam int TW = F + 1;
  localparam int C = F + 2;
  localparam int E = F + 3;
  localparam int PW2 = 2 * C;
  localparam int QW = 3 * C + 1;

  logic [TW-1:0] sin_tab [TAB_DEPTH];

  // Sine of each whole degree in 0..90 from its Taylor series, at elaboration only.
  for (genvar d = 0; d < TAB_DEPTH; d++) begin : g_tab
    localparam longint Ang = longint'((64'(d) * PI_Q30 + 64'd90) / 64'd180);
    localparam longint Term1 = ((((Ang * Ang) >>> 30) * Ang) >>> 30) / 6;
    localparam longint Term2 = ((((Term1 * Ang) >>> 30) * Ang) >>> 30) / 20;
    localparam longint Term3 = ((((Term2 * Ang) >>> 30) * Ang) >>> 30) / 42;
    localparam longint Term4 = ((((Term3 * Ang) >>> 30) * Ang) >>> 30) / 72;
    localparam longint Term5 = ((((Term4 * Ang) >>> 30) * Ang) >>> 30) / 110;
    localparam longint Term6 = ((((Term5 * Ang) >>> 30) * Ang) >>> 30) / 156;
    localparam longint Term7 = ((((Term6 * Ang) >>> 30) * Ang) >>> 30) / 210;
    localparam longint Term8 = ((((Term7 * Ang) >>> 30) * Ang) >>> 30) / 272;
    localparam longint Series = Ang - Term1 + Term2 - Term3 + Term4 - Term5 + Term6
                                - Term7 + Term8;
    localparam longint Clipped = (Series < 0) ? 64'sd0 : Series;
    localparam longint Coef = (Clipped + (64'sd1 <<< (29 - F))) >>> (30 - F);
    assign sin_tab[d] = TW'(Coef);
  end

  function automatic logic [DEG_W-1:0] wrap_deg(input logic signed [ANGLE_W-1:0] a);
    logic signed [ANGLE_W+1:0] v;
    v = (ANGLE_W + 2)'(a);
    if (a >= 360) begin
      v = v - (ANGLE_W + 2)'(360);
    end else if (a < -360) begin
      v = v + (ANGLE_W + 2)'(720);
    end else if (a < 0) begin
      v = v + (ANGLE_W + 2)'(360);
    end
    return DEG_W'(v);
  endfunction

  function automatic logic signed [E-1:0] round_entry(input logic signed [QW-1:0] v,
                                                      input int s);
    logic signed [QW-1:0] half;
    logic signed [QW-1:0] t;
    half = QW'(1) << (s - 1);
    t = v + half;
    return E'(t >>> s);
  endfunction

  logic [DEG_W-1:0] deg_r [3];
  logic [DEG_W-1:0] ang [6];
  logic signed [C-1:0] trig [6];
  logic signed [C-1:0] trig_r [6];

  always_ff @(posedge clk) begin
    deg_r[0] <= wrap_deg(angle_x);
    deg_r[1] <= wrap_deg(angle_y);
    deg_r[2] <= wrap_deg(angle_z);
  end

  // Even slots hold sine, odd slots cosine, for x, y and z in turn.
  always_comb begin
    logic [DEG_W:0] t;
    logic [QIDX_W-1:0] idx;
    logic neg;
    logic signed [C-1:0] mag;
    for (int i = 0; i < 3; i++) begin
      t = (DEG_W + 1)'(deg_r[i]) + (DEG_W + 1)'(90);
      ang[2 * i] = deg_r[i];
      ang[2 * i + 1] = (t >= 360) ? DEG_W'(t - 360) : DEG_W'(t);
    end
    for (int i = 0; i < 6; i++) begin
      if (ang[i] <= 90) begin
        idx = QIDX_W'(ang[i]);
        neg = 1'b0;
      end else if (ang[i] <= 180) begin
        idx = QIDX_W'(180 - ang[i]);
        neg = 1'b0;
      end else if (ang[i] <= 270) begin
        idx = QIDX_W'(ang[i] - 180);
        neg = 1'b1;
      end else begin
        idx = QIDX_W'(360 - ang[i]);
        neg = 1'b1;
      end
      mag = $signed({1'b0, sin_tab[idx]});
      trig[i] = neg ? -mag : mag;
    end
  end

  always_ff @(posedge clk) begin
    trig_r <= trig;
  end

  logic signed [PW2-1:0] p_cycz, p_cysz, p_sxcy, p_cxcy, p_sxsy, p_cxsy;
  logic signed [PW2-1:0] p_cxsz, p_sxsz, p_sxcz, p_cxcz;
  logic signed [C-1:0] sy_d, sz_d, cz_d;

  always_ff @(posedge clk) begin
    p_cycz <= trig_r[3] * trig_r[5];
    p_cysz <= trig_r[3] * trig_r[4];
    p_sxcy <= trig_r[0] * trig_r[3];
    p_cxcy <= trig_r[1] * trig_r[3];
    p_sxsy <= trig_r[0] * trig_r[2];
    p_cxsy <= trig_r[1] * trig_r[2];
    p_cxsz <= trig_r[1] * trig_r[4];
    p_sxsz <= trig_r[0] * trig_r[4];
    p_sxcz <= trig_r[0] * trig_r[5];
    p_cxcz <= trig_r[1] * trig_r[5];
    sy_d <= trig_r[2];
    sz_d <= trig_r[4];
    cz_d <= trig_r[5];
  end

  logic signed [QW-1:0] t_sxsycz, t_sxsysz, t_cxsycz, t_cxsysz;
  logic signed [PW2-1:0] cxsz_d, sxsz_d, sxcz_d, cxcz_d;

  always_ff @(posedge clk) begin
    t_sxsycz <= QW'(p_sxsy) * QW'(cz_d);
    t_sxsysz <= QW'(p_sxsy) * QW'(sz_d);
    t_cxsycz <= QW'(p_cxsy) * QW'(cz_d);
    t_cxsysz <= QW'(p_cxsy) * QW'(sz_d);
    cxsz_d <= p_cxsz;
    sxsz_d <= p_sxsz;
    sxcz_d <= p_sxcz;
    cxcz_d <= p_cxcz;
    mat[0][0] <= round_entry(QW'(p_cycz), F);
    mat[0][1] <= round_entry(-QW'(p_cysz), F);
    mat[0][2] <= E'(sy_d);
    mat[1][2] <= round_entry(-QW'(p_sxcy), F);
    mat[2][2] <= round_entry(QW'(p_cxcy), F);
    mat[1][0] <= round_entry(t_sxsycz + (QW'(cxsz_d) <<< F), 2 * F);
    mat[1][1] <= round_entry((QW'(cxcz_d) <<< F) - t_sxsysz, 2 * F);
    mat[2][0] <= round_entry((QW'(sxsz_d) <<< F) - t_cxsycz, 2 * F);
    mat[2][1] <= round_entry(t_cxsysz + (QW'(sxcz_d) <<< F), 2 * F);
  end

endmodule

FILE: rtl/core/ers_lane.sv
module ers_lane #(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                            clk,
  input  ers_pkg::lane_en_t               en,
  input  logic signed [COEF_FRAC_BITS+2:0] row [3],
  input  logic signed [COORD_WIDTH-1:0]   vec [3],
  output logic signed [COORD_WIDTH-1:0]   res
);
  import ers_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam int F = COEF_FRAC_BITS;
  localparam int E = F + 3;
  localparam int PW = E + W;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (F - 1);
  localparam logic signed [SW-1:0] SAT_HI = (SW'(1) << (W - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

  logic signed [PW-1:0] prod [3];
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] rounded;
  logic signed [W-1:0] res_next;

  always_ff @(posedge clk) begin
    if (en.prod) begin
      for (int j = 0; j < 3; j++) begin
        prod[j] <= row[j] * vec[j];
      end
    end
    if (en.sum) begin
      sum <= SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]);
    end
    if (en.rnd) begin
      res <= res_next;
    end
  end

  always_comb begin
    rounded = (sum + HALF) >>> F;
    if (rounded > SAT_HI) begin
      res_next = W'(SAT_HI);
    end else if (rounded < SAT_LO) begin
      res_next = W'(SAT_LO);
    end else begin
      res_next = W'(rounded);
    end
  end

endmodule

FILE: rtl/core/ers_post.sv
module ers_post #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  ers_pkg::post_en_t             en,
  input  logic                          order_mode,
  input  logic signed [COORD_WIDTH-1:0] rot,
  input  logic signed [COORD_WIDTH-1:0] shift,
  input  logic signed [COORD_WIDTH-1:0] scale,
  output logic signed [COORD_WIDTH-1:0] res
);
  import ers_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam int MW = 2 * W;
  localparam logic signed [W-1:0] W_MAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic signed [W-1:0] W_MIN = {1'b1, {(W - 1){1'b0}}};
  localparam logic signed [MW-1:0] HALF = MW'(1) << (POS_FRAC - 1);
  localparam logic signed [MW-1:0] SAT_HI = MW'(W_MAX);
  localparam logic signed [MW-1:0] SAT_LO = MW'(W_MIN);

  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = (W + 1)'(a) + (W + 1)'(b);
    if (s[W] != s[W-1]) begin
      return s[W] ? W_MIN : W_MAX;
    end
    return s[W-1:0];
  endfunction

  logic signed [W-1:0] pre_r;
  logic signed [MW-1:0] mul_r;
  logic signed [MW-1:0] scaled;
  logic signed [W-1:0] scl_next;
  logic signed [W-1:0] scl_r;

  always_comb begin
    scaled = (mul_r + HALF) >>> POS_FRAC;
    if (scaled > SAT_HI) begin
      scl_next = W_MAX;
    end else if (scaled < SAT_LO) begin
      scl_next = W_MIN;
    end else begin
      scl_next = W'(scaled);
    end
  end

  always_ff @(posedge clk) begin
    if (en.pre) begin
      pre_r <= order_mode ? sat_add(rot, shift) : rot;
    end
    if (en.mul) begin
      mul_r <= MW'(pre_r) * MW'(scale);
    end
    if (en.scl) begin
      scl_r <= scl_next;
    end
    if (en.add) begin
      res <= order_mode ? scl_r : sat_add(scl_r, shift);
    end
  end

endmodule

FILE: rtl/core/euler_rotate_scale_translate.sv
// Each accepted vertex passes the product, sum, round, pre-add, multiply, scale and add stages.
// Throughput is one vertex per cycle while in_stall is low; bubbles collapse, so input is taken
// while a result waits. The rotation matrix is rebuilt from the sine table after reset
// and after every configuration write, and the input is stalled until it settles.
// Reset is synchronous: registers return to their defaults (scale 1.0) and the pipeline empties.
module euler_rotate_scale_translate #(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ers_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [COORD_WIDTH-1:0]              cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_WIDTH-1:0]       pos_x,
  input  logic signed [COORD_WIDTH-1:0]       pos_y,
  input  logic signed [COORD_WIDTH-1:0]       pos_z,
  input  logic signed [COORD_WIDTH-1:0]       norm_x,
  input  logic signed [COORD_WIDTH-1:0]       norm_y,
  input  logic signed [COORD_WIDTH-1:0]       norm_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [COORD_WIDTH-1:0]       out_pos_x,
  output logic signed [COORD_WIDTH-1:0]       out_pos_y,
  output logic signed [COORD_WIDTH-1:0]       out_pos_z,
  output logic signed [COORD_WIDTH-1:0]       out_norm_x,
  output logic signed [COORD_WIDTH-1:0]       out_norm_y,
  output logic signed [COORD_WIDTH-1:0]       out_norm_z
);
  import ers_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam int E = COEF_FRAC_BITS + 3;

  logic order_mode;
  logic signed [ANGLE_W-1:0] angle_x, angle_y, angle_z;
  logic signed [W-1:0] shift [3];
  logic signed [W-1:0] scale_factor;
  logic [SETTLE_W-1:0] settle;
  logic cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= 1'b0;
      angle_x <= '0;
      angle_y <= '0;
      angle_z <= '0;
      shift[0] <= '0;
      shift[1] <= '0;
      shift[2] <= '0;
      scale_factor <= W'(SCALE_RESET);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORDER_MODE: order_mode <= cfg_data[0];
        REG_ANGLE_X:    angle_x <= cfg_data[ANGLE_W-1:0];
        REG_ANGLE_Y:    angle_y <= cfg_data[ANGLE_W-1:0];
        REG_ANGLE_Z:    angle_z <= cfg_data[ANGLE_W-1:0];
        REG_SHIFT_X:    shift[0] <= cfg_data;
        REG_SHIFT_Y:    shift[1] <= cfg_data;
        REG_SHIFT_Z:    shift[2] <= cfg_data;
        REG_SCALE:      scale_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      settle <= SETTLE_W'(MAT_LAT);
    end else if (settle != '0) begin
      settle <= settle - 1'b1;
    end
  end

  logic signed [E-1:0] mat [3][3];

  ers_coef #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_coef (
    .clk     (clk),
    .angle_x (angle_x),
    .angle_y (angle_y),
    .angle_z (angle_z),
    .mat     (mat)
  );

  logic [NUM_STAGES:1] vld;
  logic [NUM_STAGES:1] en_stage;
  logic accept;

  always_comb begin
    en_stage[NUM_STAGES] = !vld[NUM_STAGES] || !out_stall;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      en_stage[k] = !vld[k] || en_stage[k+1];
    end
  end

  assign in_stall = !en_stage[ST_PROD] || (settle != '0);
  assign accept = in_valid && !in_stall;
  assign out_valid = vld[NUM_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en_stage[ST_PROD]) begin
        vld[ST_PROD] <= accept;
      end
      for (int k = ST_PROD + 1; k <= NUM_STAGES; k++) begin
        if (en_stage[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  lane_en_t lane_en;
  post_en_t post_en;

  assign lane_en = '{prod: en_stage[ST_PROD], sum: en_stage[ST_SUM], rnd: en_stage[ST_RND]};
  assign post_en = '{pre: en_stage[ST_PRE], mul: en_stage[ST_MUL],
                     scl: en_stage[ST_SCL], add: en_stage[ST_ADD]};

  logic signed [W-1:0] pos_vec [3];
  logic signed [W-1:0] norm_vec [3];
  logic signed [W-1:0] rot_pos [3];
  logic signed [W-1:0] rot_norm [3];
  logic signed [W-1:0] pos_res [3];

  assign pos_vec[0] = pos_x;
  assign pos_vec[1] = pos_y;
  assign pos_vec[2] = pos_z;
  assign norm_vec[0] = norm_x;
  assign norm_vec[1] = norm_y;
  assign norm_vec[2] = norm_z;

  for (genvar i = 0; i < 3; i++) begin : g_row
    ers_lane #(
      .COORD_WIDTH    (COORD_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_pos_lane (
      .clk (clk),
      .en  (lane_en),
      .row (mat[i]),
      .vec (pos_vec),
      .res (rot_pos[i])
    );

    ers_lane #(
      .COORD_WIDTH    (COORD_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_norm_lane (
      .clk (clk),
      .en  (lane_en),
      .row (mat[i]),
      .vec (norm_vec),
      .res (rot_norm[i])
    );

    ers_post #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_post (
      .clk        (clk),
      .en         (post_en),
      .order_mode (order_mode),
      .rot        (rot_pos[i]),
      .shift      (shift[i]),
      .scale      (scale_factor),
      .res        (pos_res[i])
    );
  end

  // Normals skip scale and translate, so they are delayed to line up with positions.
  logic signed [W-1:0] norm_pipe [NORM_DLY][3];

  always_ff @(posedge clk) begin
    if (en_stage[ST_PRE]) begin
      norm_pipe[0] <= rot_norm;
    end
    for (int k = 1; k < NORM_DLY; k++) begin
      if (en_stage[ST_PRE+k]) begin
        norm_pipe[k] <= norm_pipe[k-1];
      end
    end
  end

  assign out_pos_x = pos_res[0];
  assign out_pos_y = pos_res[1];
  assign out_pos_z = pos_res[2];
  assign out_norm_x = norm_pipe[NORM_DLY-1][0];
  assign out_norm_y = norm_pipe[NORM_DLY-1][1];
  assign out_norm_z = norm_pipe[NORM_DLY-1][2];

endmodule

FILE: rtl/core/ers_checker.sv
module ers_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [COORD_WIDTH-1:0] out_pos_x,
  input logic signed [COORD_WIDTH-1:0] out_pos_y,
  input logic signed [COORD_WIDTH-1:0] out_pos_z,
  input logic signed [COORD_WIDTH-1:0] out_norm_x,
  input logic signed [COORD_WIDTH-1:0] out_norm_y,
  input logic signed [COORD_WIDTH-1:0] out_norm_z
);
  import ers_pkg::*;

  logic [CNT_W-1:0] inflight;
  logic [CNT_W-1:0] inflight_next;
  logic in_take;
  logic out_take;

  assign in_take = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  always_comb begin
    inflight_next = inflight + CNT_W'(in_take) - CNT_W'(out_take);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> in_stall)
    else $error("request taken while the matrix is being rebuilt");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != '0)
    else $error("result without a request in flight");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= CNT_W'(NUM_STAGES))
    else $error("more requests in flight than pipeline stages");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_pos_x) && $stable(out_pos_y)
      && $stable(out_pos_z) && $stable(out_norm_x) && $stable(out_norm_y)
      && $stable(out_norm_z))
    else $error("stalled result changed");

endmodule

bind euler_rotate_scale_translate ers_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_ers_checker (
  .clk        (clk),
  .rst        (rst),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_pos_x  (out_pos_x),
  .out_pos_y  (out_pos_y),
  .out_pos_z  (out_pos_z),
  .out_norm_x (out_norm_x),
  .out_norm_y (out_norm_y),
  .out_norm_z (out_norm_z)
);
